// ----- design/cgd_pkg.sv -----
package cgd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_ANGLE_BITS = 16;
    localparam int MAX_HEIGHT     = 4096;

    localparam int COST_BITS  = 8;
    localparam int DIFF_BITS  = 11;
    localparam int ANGLE_OUT  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    // request into the shared arctangent unit
    typedef struct packed {
        logic                        start;
        logic signed [DIFF_BITS-1:0] xdiff;
        logic signed [DIFF_BITS-1:0] ydiff;
    } cgd_req_t;

    // result back from the arctangent unit
    typedef struct packed {
        logic                        done;
        logic signed [ANGLE_OUT-1:0] angle;
    } cgd_rsp_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] cgd_atan(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- design/cgd_cordic.sv -----
module cgd_cordic
    import cgd_pkg::*;
#(
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cgd_req_t req,
    output cgd_rsp_t rsp
);

    localparam int STEPS = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;
    localparam int SW    = $clog2(STEPS);
    localparam int XW    = 34;
    localparam int SCALE = 20;

    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys, x0, y0;
    logic [31:0]          acc_reg, acc_next;
    logic [SW-1:0]        step_reg;
    logic                 run_reg, done_reg;
    logic [31:0]          rounded;
    logic signed [ANGLE_BITS-1:0] ang;

    assign x0 = XW'(req.xdiff) <<< SCALE;
    assign y0 = XW'(req.ydiff) <<< SCALE;
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;

    always_comb
    begin
        if (y_reg > 0)
        begin
            x_next   = x_reg + ys;
            y_next   = y_reg - xs;
            acc_next = acc_reg + cgd_atan(5'(step_reg));
        end
        else
        begin
            x_next   = x_reg - ys;
            y_next   = y_reg + xs;
            acc_next = acc_reg - cgd_atan(5'(step_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            acc_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= '0;
                x_reg    <= x0;
                y_reg    <= y0;
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
                priority if (req.xdiff == 0 && req.ydiff == 0)
                    acc_reg <= 32'h0;
                else if (req.ydiff == 0)
                    acc_reg <= (req.xdiff > 0) ? 32'h0 : 32'h80000000;
                else if (req.xdiff == 0)
                    acc_reg <= (req.ydiff > 0) ? 32'h40000000 : 32'hC0000000;
                else
                begin
                    done_reg <= 1'b0;
                    run_reg  <= 1'b1;
                    if (req.xdiff < 0)
                    begin
                        x_reg   <= -x0;
                        y_reg   <= -y0;
                        acc_reg <= 32'h80000000;
                    end
                    else
                        acc_reg <= 32'h0;
                end
            end
            else if (run_reg)
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                acc_reg  <= acc_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // round half up to ANGLE_BITS, wrap, then sign-extend or trim to 16 bits
    assign rounded   = acc_reg + (32'd1 << (31 - ANGLE_BITS));
    assign ang       = rounded[31 -: ANGLE_BITS];
    assign rsp.done  = done_reg;
    assign rsp.angle = ANGLE_OUT'(ang);

endmodule

// ----- design/cost_map_gradient_direction_unit.sv -----
// Gradient direction of a directed cost map. Cells arrive in raster order (column fastest,
// row 0 first), one transaction per cell with four cost bytes; each result transaction
// carries the angle atan2(ydiff, xdiff) as a signed binary angle (32768 = pi), the cell's
// column and row, and frame_last on the final cell. A cell is reported when the cell below
// it arrives; cells of the last row are reported one cell late, the row's last cell at once,
// so one input transaction yields zero to three results. Every cell passes through accept,
// four row-store steps, the end-of-slots check and the position update, plus a slot check
// for each of its three result slots. A result adds the start, the load of the single
// shared arctangent unit, its CORDIC steps, done and output; the CORDIC steps are skipped
// when the vector lies on an axis or is zero, and the result waits while the receiver
// stalls. The input is not ready while a cell is in work. Writing grid_width or
// grid_height restarts the grid.
module cost_map_gradient_direction_unit
    import cgd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COST_BITS-1:0]        x_up_cost,
    input  logic [COST_BITS-1:0]        x_down_cost,
    input  logic [COST_BITS-1:0]        y_up_cost,
    input  logic [COST_BITS-1:0]        y_down_cost,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [ANGLE_OUT-1:0] direction_angle,
    output logic [9:0]                  cell_column,
    output logic [11:0]                 cell_row,
    output logic                        frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = 12;
    localparam int HW = 13;

    typedef struct packed {
        logic [COST_BITS-1:0] yd;
        logic [COST_BITS-1:0] yu;
        logic [COST_BITS-1:0] xd;
        logic [COST_BITS-1:0] xu;
    } cell_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_JOB, S_CALC, S_OUT, S_END
    } state_t;

    state_t state_reg;

    // configuration and position
    logic [10:0]   gw_reg;
    logic [HW-1:0] gh_reg;
    logic [CW-1:0] col_cnt_reg, c_reg;
    logic [RW-1:0] row_cnt_reg, r_reg;
    logic [CW:0]   w_eff;
    logic [CW-1:0] w_m1;
    logic [HW-1:0] h_eff;
    logic [RW-1:0] h_m1;

    // row stores
    cell_t                prev_mem [MAX_WIDTH];
    logic [COST_BITS-1:0] older_mem [MAX_WIDTH];
    cell_t                prev_q;
    logic [COST_BITS-1:0] older_q;
    logic [CW-1:0]        prev_addr, older_addr;
    logic                 wr_en;

    // working cells
    cell_t                cur_reg, up_reg, right_reg, left_reg, held0_reg, held1_reg;
    logic [COST_BITS-1:0] older_c_reg, older_cm1_reg;
    logic [1:0]           job_reg;
    logic                 start_reg;

    // per-result operands
    cell_t                own, lft, rgt;
    logic [COST_BITS-1:0] above_yd, below_yu;
    logic                 has_l, has_r, has_a, has_b, job_en;
    logic [CW-1:0]        job_col;
    logic [RW-1:0]        job_row;
    logic                 job_last;
    logic                 c_gt0, c_gt1, c_has_r, r_gt0, r_gt1, r_last, c_last;

    cgd_req_t req;
    cgd_rsp_t rsp;

    logic signed [ANGLE_OUT-1:0] angle_reg;
    logic [CW-1:0]               col_out_reg;
    logic [RW-1:0]               row_out_reg;
    logic                        last_reg, out_valid_reg;

    function automatic logic signed [DIFF_BITS-1:0] term(input logic [COST_BITS-1:0] a,
                                                         input logic [COST_BITS-1:0] b,
                                                         input logic en);
        logic signed [DIFF_BITS-1:0] d;
        begin
            d = $signed(DIFF_BITS'(a)) - $signed(DIFF_BITS'(b));
            return en ? d : '0;
        end
    endfunction

    // clamp the sizes to what the stores can hold
    always_comb
    begin
        if (gw_reg == '0)
            w_eff = (CW + 1)'(1);
        else if (32'(gw_reg) > 32'(MAX_WIDTH))
            w_eff = (CW + 1)'(MAX_WIDTH);
        else
            w_eff = (CW + 1)'(gw_reg);
        if (gh_reg == '0)
            h_eff = HW'(1);
        else if (gh_reg > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = gh_reg;
    end
    assign w_m1 = CW'(w_eff - 1'b1);
    assign h_m1 = RW'(h_eff - 1'b1);

    assign c_gt0   = (c_reg != '0);
    assign c_gt1   = (c_reg > CW'(1));
    assign c_has_r = (({1'b0, c_reg} + 1'b1) < w_eff);
    assign c_last  = (c_reg == w_m1);
    assign r_gt0   = (r_reg != '0);
    assign r_gt1   = (r_reg > RW'(1));
    assign r_last  = (r_reg == h_m1);

    // memory addressing by sequencer step
    always_comb
    begin
        prev_addr  = c_reg;
        older_addr = c_reg;
        wr_en      = 1'b0;
        unique case (state_reg)
            S_RD1:
            begin
                prev_addr  = CW'(c_reg + 1'b1);
                older_addr = CW'(c_reg - 1'b1);
            end
            S_RD2:   prev_addr = CW'(c_reg - 2'd2);
            S_RD3:   wr_en = 1'b1;
            default: prev_addr = c_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prev_q  <= prev_mem[prev_addr];
        older_q <= older_mem[older_addr];
        if (wr_en)
        begin
            prev_mem[c_reg] <= cur_reg;
            if (r_gt0)
                older_mem[c_reg] <= up_reg.yd;
        end
    end

    // pick the cell under evaluation and its neighbors
    always_comb
    begin
        own      = cur_reg;
        lft      = held1_reg;
        rgt      = right_reg;
        above_yd = up_reg.yd;
        below_yu = cur_reg.yu;
        has_l    = c_gt0;
        has_r    = 1'b0;
        has_a    = r_gt0;
        has_b    = 1'b0;
        job_en   = 1'b0;
        job_col  = c_reg;
        job_row  = r_reg;
        job_last = 1'b0;
        unique case (job_reg)
            2'd0:
            begin
                own      = up_reg;
                lft      = held0_reg;
                has_r    = c_has_r;
                above_yd = older_c_reg;
                has_a    = r_gt1;
                has_b    = 1'b1;
                job_en   = r_gt0;
                job_row  = RW'(r_reg - 1'b1);
            end
            2'd1:
            begin
                own      = held1_reg;
                lft      = left_reg;
                has_l    = c_gt1;
                rgt      = cur_reg;
                has_r    = 1'b1;
                above_yd = older_cm1_reg;
                job_en   = r_last && c_gt0;
                job_col  = CW'(c_reg - 1'b1);
            end
            2'd2:
            begin
                job_en   = r_last && c_last;
                job_last = 1'b1;
            end
            default: job_en = 1'b0;
        endcase
    end

    assign req.start = start_reg;
    assign req.xdiff = term(own.xd, rgt.xu, has_r) + term(lft.xd, own.xu, has_l);
    assign req.ydiff = term(own.yd, below_yu, has_b) + term(above_yd, own.yu, has_a);

    cgd_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gw_reg        <= 11'd64;
            gh_reg        <= HW'(64);
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            held0_reg     <= '0;
            held1_reg     <= '0;
            job_reg       <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            c_reg         <= '0;
            r_reg         <= '0;
            cur_reg       <= '0;
            up_reg        <= '0;
            right_reg     <= '0;
            left_reg      <= '0;
            older_c_reg   <= '0;
            older_cm1_reg <= '0;
            angle_reg     <= '0;
            col_out_reg   <= '0;
            row_out_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        // any register write restarts the grid
                        if (cfg_index == REG_GRID_WIDTH)
                            gw_reg <= cfg_data[10:0];
                        else
                            gh_reg <= cfg_data;
                        col_cnt_reg <= '0;
                        row_cnt_reg <= '0;
                        held0_reg   <= '0;
                        held1_reg   <= '0;
                    end
                    else if (in_valid)
                    begin
                        cur_reg <= '{yd: y_down_cost, yu: y_up_cost,
                                     xd: x_down_cost, xu: x_up_cost};
                        c_reg   <= ({1'b0, col_cnt_reg} >= w_eff) ? w_m1 : col_cnt_reg;
                        r_reg   <= (row_cnt_reg >= RW'(h_eff)) && (h_eff <= HW'(MAX_HEIGHT - 1))
                                   ? h_m1 : row_cnt_reg;
                        state_reg <= S_RD0;
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    up_reg      <= prev_q;
                    older_c_reg <= older_q;
                    state_reg   <= S_RD2;
                end
                S_RD2:
                begin
                    right_reg     <= prev_q;
                    older_cm1_reg <= older_q;
                    state_reg     <= S_RD3;
                end
                S_RD3:
                begin
                    left_reg  <= prev_q;
                    job_reg   <= 2'd0;
                    state_reg <= S_JOB;
                end
                S_JOB:
                begin
                    if (job_reg == 2'd3)
                        state_reg <= S_END;
                    else if (job_en)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= S_CALC;
                    end
                    else
                        job_reg <= job_reg + 1'b1;
                end
                S_CALC:
                begin
                    start_reg <= 1'b0;
                    if (rsp.done)
                    begin
                        angle_reg     <= rsp.angle;
                        col_out_reg   <= job_col;
                        row_out_reg   <= job_row;
                        last_reg      <= job_last;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        job_reg       <= job_reg + 1'b1;
                        state_reg     <= S_JOB;
                    end
                end
                S_END:
                begin
                    // advance the raster position and shift the held cells
                    if (r_gt0)
                        held0_reg <= up_reg;
                    held1_reg <= cur_reg;
                    if (c_last)
                    begin
                        col_cnt_reg <= '0;
                        row_cnt_reg <= r_last ? '0 : RW'(r_reg + 1'b1);
                    end
                    else
                    begin
                        col_cnt_reg <= CW'(c_reg + 1'b1);
                        row_cnt_reg <= r_reg;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign direction_angle = angle_reg;
    assign cell_column     = 10'(col_out_reg);
    assign cell_row        = row_out_reg;
    assign frame_last      = last_reg;

    // a result is only on offer while the sequencer waits for its transaction
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result offered outside output wait");

    // the arctangent unit reports only for a request of this cell
    a_done_calc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> state_reg == S_CALC)
        else $error("arctangent result with no request");

    // no new cell while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while result pending");

    // the raster column stays inside the clamped grid width after each cell
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_END |=> {1'b0, col_cnt_reg} < w_eff)
        else $error("column counter beyond grid width");

endmodule

// ----- tb/sv/cost_map_gradient_direction_unit_tb.sv -----
module cost_map_gradient_direction_unit_tb;
    import cgd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Allow for a long settle pause, one cell with three results and a stalling receiver.
    localparam int WATCHDOG_LIMIT = 20000;
    // Cycles to let the block finish a cell that produced no result.
    localparam int SETTLE_CYCLES  = 120;

    // One result transaction of the block.
    typedef struct packed {
        logic signed [ANGLE_OUT-1:0] angle;
        logic [9:0]                  column;
        logic [11:0]                 row;
        logic                        last;
    } gradient_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [COST_BITS-1:0]        x_up_cost;
    logic [COST_BITS-1:0]        x_down_cost;
    logic [COST_BITS-1:0]        y_up_cost;
    logic [COST_BITS-1:0]        y_down_cost;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [ANGLE_OUT-1:0] direction_angle;
    logic [9:0]                  cell_column;
    logic [11:0]                 cell_row;
    logic                        frame_last;

    cost_map_gradient_direction_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .x_up_cost       (x_up_cost),
        .x_down_cost     (x_down_cost),
        .y_up_cost       (y_up_cost),
        .y_down_cost     (y_down_cost),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .direction_angle (direction_angle),
        .cell_column     (cell_column),
        .cell_row        (cell_row),
        .frame_last      (frame_last)
    );

    // Free-running clock, 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the block: configuration, row stores, counters and held cells.
    logic [10:0] grid_width_reg;
    logic [12:0] grid_height_reg;
    logic [31:0] upper_row_cells [1024];
    logic [7:0]  older_ydown     [1024];
    int          column_pos;
    int          row_pos;
    logic [31:0] left_cells [2];

    gradient_t expected_gradients [$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int cells_sent;
    int gradients_checked;
    int config_writes;
    int idle_cycles;

    // atan(2^-i) as a 32-bit binary angle
    localparam logic [31:0] ARCTAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // CORDIC vectoring to a 16-bit binary angle; axes and the zero vector are exact.
    function automatic logic [15:0] gradient_angle(input int xd, input int yd);
        logic [31:0] acc;
        logic [31:0] rounded;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        int          steps;
        acc   = 32'h0;
        x     = xd;
        y     = yd;
        steps = (DEF_ANGLE_BITS < 24) ? DEF_ANGLE_BITS : 24;
        if (x == 0 && y == 0)
            acc = 32'h0;
        else if (y == 0)
            acc = (x > 0) ? 32'h0 : 32'h80000000;
        else if (x == 0)
            acc = (y > 0) ? 32'h40000000 : 32'hC0000000;
        else
        begin
            x = x <<< 20;
            y = y <<< 20;
            // left half-plane: negate and start from pi
            if (x < 0)
            begin
                x   = -x;
                y   = -y;
                acc = 32'h80000000;
            end
            for (int i = 0; i < steps; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x   = x + ys;
                    y   = y - xs;
                    acc = acc + ARCTAN_STEP[i];
                end
                else
                begin
                    x   = x - ys;
                    y   = y + xs;
                    acc = acc - ARCTAN_STEP[i];
                end
            end
        end
        rounded = (acc + (32'h1 << (31 - DEF_ANGLE_BITS))) >> (32 - DEF_ANGLE_BITS);
        return rounded[15:0];
    endfunction

    // Queue the gradient of one cell from whichever neighbors lie inside the grid.
    task automatic queue_gradient(input logic [31:0] own,
                                  input bit has_l, input logic [31:0] left,
                                  input bit has_r, input logic [31:0] right,
                                  input bit has_a, input logic [7:0] above_yd,
                                  input bit has_b, input logic [31:0] below,
                                  input int col, input int row, input bit last);
        int        xdiff;
        int        ydiff;
        gradient_t g;
        xdiff = 0;
        ydiff = 0;
        if (has_r) xdiff += int'(own[15:8]) - int'(right[7:0]);
        if (has_l) xdiff += int'(left[15:8]) - int'(own[7:0]);
        if (has_b) ydiff += int'(own[31:24]) - int'(below[23:16]);
        if (has_a) ydiff += int'(above_yd) - int'(own[23:16]);
        g.angle  = gradient_angle(xdiff, ydiff);
        g.column = col[9:0];
        g.row    = row[11:0];
        g.last   = last;
        expected_gradients = {expected_gradients, g};
    endtask

    // Advance the shadow by one accepted cell and queue what it releases.
    task automatic predict_cell(input logic [31:0] cur);
        int          w;
        int          h;
        int          c;
        int          r;
        logic [31:0] up;
        logic [31:0] right;
        logic [31:0] left;
        w = (grid_width_reg < 1) ? 1 : ((grid_width_reg > 1024) ? 1024 : int'(grid_width_reg));
        h = (grid_height_reg < 1) ? 1 : ((grid_height_reg > 4096) ? 4096 : int'(grid_height_reg));
        c = (column_pos >= w) ? w - 1 : column_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        // the cell above is complete now that its lower neighbor is here
        if (r > 0)
        begin
            up    = upper_row_cells[c];
            right = (c + 1 < w) ? upper_row_cells[c + 1] : 32'h0;
            queue_gradient(up, c > 0, left_cells[0], c + 1 < w, right,
                           r > 1, older_ydown[c], 1'b1, cur, c, r - 1, 1'b0);
            left_cells[0]  = up;
            older_ydown[c] = up[31:24];
        end
        upper_row_cells[c] = cur;
        // last row: release the left cell, and this one if it ends the row
        if (r == h - 1)
        begin
            if (c > 0)
            begin
                left = (c > 1) ? upper_row_cells[c - 2] : 32'h0;
                queue_gradient(left_cells[1], c > 1, left, 1'b1, cur,
                               r > 0, older_ydown[c - 1], 1'b0, 32'h0, c - 1, r, 1'b0);
            end
            if (c == w - 1)
                queue_gradient(cur, c > 0, left_cells[1], 1'b0, 32'h0,
                               r > 0, older_ydown[c], 1'b0, 32'h0, c, r, 1'b1);
        end
        left_cells[1] = cur;
        if (c + 1 >= w)
        begin
            column_pos = 0;
            row_pos    = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            column_pos = c + 1;
            row_pos    = r;
        end
    endtask

    // Send one cell, idling first at the sender's current rate.
    task automatic send_cell(input logic [7:0] xu, input logic [7:0] xd,
                             input logic [7:0] yu, input logic [7:0] yd);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        x_up_cost   = xu;
        x_down_cost = xd;
        y_up_cost   = yu;
        y_down_cost = yd;
        // hold until the transaction is taken
        do
            @(posedge clk);
        while (!in_ready);
        predict_cell({yd, yu, xd, xu});
        cells_sent++;
    endtask

    // Write one register once the block has drained; a write restarts the grid.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_gradients.size() == 0);
        // a cell with no result may still be in work
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_GRID_WIDTH)
            grid_width_reg = data[10:0];
        else
            grid_height_reg = data[12:0];
        column_pos    = 0;
        row_pos       = 0;
        left_cells[0] = 32'h0;
        left_cells[1] = 32'h0;
        config_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_grid(input int w, input int h);
        write_reg(REG_GRID_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(REG_GRID_HEIGHT, h[CFG_DATA_W-1:0]);
    endtask

    // Mostly random costs, with the extremes weighted in.
    function automatic logic [7:0] pick_cost();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_cell();
        send_cell(pick_cost(), pick_cost(), pick_cost(), pick_cost());
    endtask

    // Zero sizes clamp to a single cell; every gradient term drops out.
    task automatic test_single_cell();
        set_grid(0, 0);
        send_cell(8'h00, 8'h00, 8'h00, 8'h00);
        send_cell(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cell(8'hFF, 8'h00, 8'hFF, 8'h00);
    endtask

    // 3x3 grid: drive the axes, the half-plane flip and the zero vector.
    task automatic test_axes_and_extremes();
        set_grid(3, 3);
        send_cell(8'h00, 8'hFF, 8'h00, 8'hFF);
        send_cell(8'hFF, 8'h00, 8'hFF, 8'h00);
        send_cell(8'h00, 8'h00, 8'h00, 8'h00);
        send_cell(8'h00, 8'h00, 8'hFF, 8'h00);
        send_cell(8'h00, 8'hFF, 8'h00, 8'h00);
        send_cell(8'hFF, 8'h00, 8'h00, 8'hFF);
        send_cell(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cell(8'h00, 8'h00, 8'h00, 8'h00);
        send_cell(8'h80, 8'h7F, 8'h01, 8'hFE);
        // second grid after the wrap
        send_cell(8'h12, 8'h34, 8'h56, 8'h78);
    endtask

    // Oversized registers clamp; only a few cells of the huge grids are sent.
    task automatic test_clamped_sizes();
        set_grid(13'h1FFF, 1);
        repeat (4) send_random_cell();
        set_grid(1, 13'h1FFF);
        repeat (4) send_random_cell();
        set_grid(1024, 4096);
        repeat (3) send_random_cell();
    endtask

    // Random small grids per idling phase, some cut short by a new setting.
    task automatic test_random_grids(input int quota);
        int w;
        int h;
        int n;
        int sent;
        sent = 0;
        while (sent < quota)
        begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 4);
            set_grid(w, h);
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(3) == 0)
                n = $urandom_range(1, n);
            repeat (n) send_random_cell();
            sent += n;
        end
    endtask

    // Receiver: drop ready at random at the current stall rate.
    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_stall_pct);

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        gradient_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_gradients.size() == 0)
            begin
                $display("%0t: unexpected result angle=%0d col=%0d row=%0d last=%0b",
                         $time, direction_angle, cell_column, cell_row, frame_last);
                error_count++;
            end
            else
            begin
                want = expected_gradients.pop_front();
                if (want.angle !== direction_angle || want.column !== cell_column ||
                    want.row !== cell_row || want.last !== frame_last)
                begin
                    $display("%0t: mismatch expected angle=%0d col=%0d row=%0d last=%0b",
                             $time, want.angle, want.column, want.row, want.last);
                    $display("%0t:          actual   angle=%0d col=%0d row=%0d last=%0b",
                             $time, direction_angle, cell_column, cell_row, frame_last);
                    error_count++;
                end
                gradients_checked++;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_gradients.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = REG_GRID_WIDTH;
        cfg_data          = '0;
        in_valid          = 1'b0;
        x_up_cost         = '0;
        x_down_cost       = '0;
        y_up_cost         = '0;
        y_down_cost       = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        error_count       = 0;
        cells_sent        = 0;
        gradients_checked = 0;
        config_writes     = 0;
        idle_cycles       = 0;
        grid_width_reg    = 11'd64;
        grid_height_reg   = 13'd64;
        column_pos        = 0;
        row_pos           = 0;
        left_cells[0]     = 32'h0;
        left_cells[1]     = 32'h0;
        for (int i = 0; i < 1024; i++)
        begin
            upper_row_cells[i] = 32'h0;
            older_ydown[i]     = 8'h0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_cell();
        test_axes_and_extremes();
        test_clamped_sizes();

        // no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_grids(22);
        // sender idle
        send_idle_pct  = 60;
        recv_stall_pct = 0;
        test_random_grids(22);
        // receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        test_random_grids(22);
        // both
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        test_random_grids(22);

        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_gradients.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d cells over %0d register writes, checked %0d gradients,",
                 cells_sent, config_writes, gradients_checked);
        $display("clamped and single-cell grids and four idling phases included.");
        if (error_count == 0 && expected_gradients.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/cgd_pkg.sv
design/cgd_cordic.sv
design/cost_map_gradient_direction_unit.sv
tb/sv/cost_map_gradient_direction_unit_tb.sv
